// ===== rtl/block_buffer_lru_cache_tags_assert.svh =====
// Assertion macros shared by the cache tag manager checkers.
// No dependencies.
`ifndef BLOCK_BUFFER_LRU_CACHE_TAGS_ASSERT_SVH
`define BLOCK_BUFFER_LRU_CACHE_TAGS_ASSERT_SVH
// implication checked every clock outside reset
`define BBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define BBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

// ===== rtl/bbc_pkg.sv =====
// Shared types and codes for the block buffer cache tag manager.
// No dependencies.
package bbc_pkg;
	localparam int unsigned NBUF = 8;
	localparam int unsigned IW = 3;

	typedef enum logic [2:0] {
		OP_GET = 3'd0, OP_PUT = 3'd1, OP_DIRTY = 3'd2, OP_BRANCH = 3'd3,
		OP_DISCARD = 3'd4, OP_DRANGE = 3'd5, OP_FRANGE = 3'd6, OP_BAD = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_INVALID = 2'd1, ST_BUSY = 2'd2, ST_CONFLICT = 2'd3
	} stat_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] block;
		logic [31:0] range_count;
		logic [7:0]  volume;
		logic [2:0]  buffer_index;
		logic        want_new;
		logic        want_dirty;
		logic [2:0]  kind;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  result_index;
		logic        was_hit;
		logic        fill_needed;
		logic        writeback_valid;
		logic [31:0] writeback_block;
		logic [7:0]  writeback_volume;
		logic [2:0]  writeback_kind;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_ROUTE, S_VICTIM, S_SHIFT, S_EMIT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // latch request
		logic scan;      // examine buffer at scan pointer
		logic decide;    // act on single-buffer op / get lookup
		logic vstep;     // examine recency position for victim
		logic shift;     // one step of recency move
		logic emit;      // drive the result
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic scan_done;
		logic need_victim;
		logic need_shift;
		logic victim_done;
		logic shift_done;
		logic frange_more;  // another flush result pending after this one
		logic is_scan_op;
	} sts_t;
endpackage

// ===== rtl/block_buffer_lru_cache_tags.sv =====
// Top level of the block buffer cache tag manager.
// Depends on bbc_pkg, bbc_ctrl and bbc_dp.
//
// One operation at a time: assert start with the request while busy is low.
// A get, put, dirty, branch or discard scans all 8 buffers, one buffer per
// cycle, then passes a decide and a routing state. A range operation or a
// bad code skips the decide state, and a bad code, an invalid range or a
// referenced buffer met by a discard range ends the scan early. A get miss
// walks the recency order from the LRU end for a victim, and moving a
// buffer in the recency order takes a locate step, one swap per position
// and a closing step. Results appear for one cycle each on rsp with
// rsp_valid; they cannot be stalled. A flush range gives one transaction
// per dirty buffer found, the final one carrying last.
module block_buffer_lru_cache_tags import bbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	output logic        rsp_valid,
	output rsp_t        rsp
);
	cmd_t cmd;
	sts_t sts;

	bbc_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .cmd);
	bbc_dp u_dp (.clk, .arst_n, .cfg_we, .cfg_data, .req, .cmd, .sts, .rsp);

	assign rsp_valid = cmd.emit;
endmodule

// ===== rtl/bbc_ctrl.sv =====
// Controller FSM for the cache tag manager.
// Depends on bbc_pkg.
module bbc_ctrl import bbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			S_IDLE:   if (start) nxt = S_SCAN;
			S_SCAN:   if (sts.scan_done) nxt = sts.is_scan_op ? S_ROUTE : S_DECIDE;
			S_DECIDE: nxt = S_ROUTE;
			// decide results are registered by now
			S_ROUTE: begin
				if (sts.need_victim) nxt = S_VICTIM;
				else if (sts.need_shift) nxt = S_SHIFT;
				else nxt = S_EMIT;
			end
			S_VICTIM: if (sts.victim_done) nxt = sts.need_shift ? S_SHIFT : S_EMIT;
			S_SHIFT:  if (sts.shift_done) nxt = S_EMIT;
			S_EMIT:   nxt = sts.frange_more ? S_EMIT : S_IDLE;
			default:  nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE:   cmd.load = start;
			S_SCAN:   cmd.scan = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_ROUTE:  cmd = '0;
			S_VICTIM: cmd.vstep = 1'b1;
			S_SHIFT:  cmd.shift = 1'b1;
			S_EMIT:   cmd.emit = 1'b1;
			default:  cmd = '0;
		endcase
	end
endmodule

// ===== rtl/bbc_dp.sv =====
// Datapath: tag store, counts, recency order and result formatting.
// Depends on bbc_pkg.
module bbc_dp import bbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  req_t        req,
	input  cmd_t        cmd,
	output sts_t        sts,
	output rsp_t        rsp
);
	logic [31:0] bcnt_q;
	req_t        r_q;
	logic [31:0] tblk_q [NBUF];
	logic [NBUF-1:0] tval_q, dirty_q;
	logic [7:0]  tvol_q [NBUF];
	logic [7:0]  refc_q [NBUF];
	logic [2:0]  kind_q [NBUF];
	logic [IW-1:0] ord_q [NBUF];
	logic [3:0]  used_q;

	logic [IW:0] ptr_q;          // scan / recency pointer
	logic        hit_q;
	logic [IW-1:0] hidx_q;       // hit buffer, victim or discarded buffer
	logic [1:0]  stat_q;
	logic        bad_q;          // request checks failed
	logic        stop_q;         // discard range hit a referenced buffer
	logic [NBUF-1:0] fl_q;       // buffers flagged for flush
	logic        vic_q;
	logic        mru_q;          // direction of recency move
	logic [IW:0] spos_q;         // position of buffer in recency order
	logic        found_q;
	logic        wbv_q, fill_q;
	logic [31:0] wbb_q;
	logic [7:0]  wbvol_q;
	logic [2:0]  wbk_q;
	logic [NBUF-1:0] dq_q;       // discard-range: buffers to move to LRU

	op_t op;
	assign op = op_t'(r_q.operation);
	logic [IW-1:0] pi;
	assign pi = ptr_q[IW-1:0];
	logic [IW-1:0] bi;
	assign bi = r_q.buffer_index;

	logic range_ok, inr, bok;
	logic [32:0] rend;
	assign rend = {1'b0, r_q.block} + {1'b0, r_q.range_count};
	assign range_ok = (r_q.block < bcnt_q) && (r_q.range_count != 0)
		&& ((bcnt_q - r_q.block) >= r_q.range_count);
	assign inr = tval_q[pi] && (tvol_q[pi] == r_q.volume) && (tblk_q[pi] >= r_q.block)
		&& ({1'b0, tblk_q[pi]} < rend);
	assign bok = tval_q[bi] && (tvol_q[bi] == r_q.volume);

	logic [IW-1:0] fidx;
	logic fany, fmore;
	always_comb begin
		fidx = '0;
		fany = 1'b0;
		fmore = 1'b0;
		for (int i = NBUF-1; i >= 0; i--)
			if (fl_q[i]) begin
				if (fany) fmore = 1'b1;
				fidx = IW'(i);
				fany = 1'b1;
			end
	end

	assign sts.is_scan_op = (op == OP_DRANGE) || (op == OP_FRANGE) || (op == OP_BAD);
	assign sts.scan_done = ptr_q[IW] || (op == OP_BAD) || stop_q
		|| (sts.is_scan_op && !range_ok);
	assign sts.need_victim = (op == OP_GET) && !bad_q && !hit_q && (stat_q == ST_OK);
	assign sts.need_shift = mru_q || found_q || ((op == OP_DRANGE) && (dq_q != '0));
	assign sts.victim_done = vic_q;
	// discard range: done once every dropped buffer sits at the LRU end
	assign sts.shift_done = (op == OP_DRANGE) ? (dq_q == '0)
		: mru_q ? (spos_q == '0) : (spos_q == (IW+1)'(NBUF-1));
	assign sts.frange_more = (op == OP_FRANGE) && fmore;

	always_comb begin
		rsp = '0;
		rsp.status = stat_q;
		rsp.last = !sts.frange_more;
		if (op == OP_FRANGE && fany && stat_q == ST_OK) begin
			rsp.result_index = fidx;
			rsp.writeback_valid = 1'b1;
			rsp.writeback_block = tblk_q[fidx];
			rsp.writeback_volume = tvol_q[fidx];
			rsp.writeback_kind = kind_q[fidx];
		end else if (op == OP_GET && stat_q == ST_OK) begin
			rsp.result_index = hidx_q;
			rsp.was_hit = hit_q;
			rsp.fill_needed = fill_q;
			rsp.writeback_valid = wbv_q;
			rsp.writeback_block = wbb_q;
			rsp.writeback_volume = wbvol_q;
			rsp.writeback_kind = wbk_q;
		end
	end

	// discard range moves dropped buffers lowest index first
	logic [IW-1:0] first_dq;
	always_comb begin
		first_dq = '0;
		for (int i = NBUF-1; i >= 0; i--) if (dq_q[i]) first_dq = IW'(i);
	end

	// target of the current recency move
	logic [IW-1:0] tgt;
	assign tgt = (op == OP_DRANGE) ? first_dq : hidx_q;

	// current position of the target in the recency order
	logic [IW:0] tpos;
	always_comb begin
		tpos = '0;
		for (int p = NBUF-1; p >= 0; p--) if (ord_q[p] == tgt) tpos = (IW+1)'(p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '1;
			tval_q <= '0;
			dirty_q <= '0;
			used_q <= '0;
			for (int i = 0; i < NBUF; i++) begin
				tblk_q[i] <= '1;
				tvol_q[i] <= '0;
				refc_q[i] <= '0;
				kind_q[i] <= '0;
				ord_q[i] <= IW'(NBUF-1-i);
			end
			r_q <= '0;
			ptr_q <= '0; hit_q <= 1'b0; stop_q <= 1'b0; fl_q <= '0; dq_q <= '0;
			mru_q <= 1'b0; found_q <= 1'b0; vic_q <= 1'b0; bad_q <= 1'b0;
			stat_q <= ST_OK; wbv_q <= 1'b0; fill_q <= 1'b0; wbb_q <= '0;
			wbvol_q <= '0; wbk_q <= '0; hidx_q <= '0; spos_q <= '1;
		end else begin
			if (cfg_we) bcnt_q <= cfg_data;
			if (cmd.load) begin
				r_q <= req;
				ptr_q <= '0; hit_q <= 1'b0; stop_q <= 1'b0; fl_q <= '0; dq_q <= '0;
				mru_q <= 1'b0; found_q <= 1'b0; vic_q <= 1'b0;
				stat_q <= ST_OK; wbv_q <= 1'b0; fill_q <= 1'b0; wbb_q <= '0;
				wbvol_q <= '0; wbk_q <= '0; hidx_q <= '0;
				bad_q <= 1'b0;
				spos_q <= '1;
			end
			if (cmd.scan) begin
				if (op == OP_BAD) stat_q <= ST_INVALID;
				else if (sts.is_scan_op && !range_ok) stat_q <= ST_INVALID;
				else if (!sts.scan_done) begin
					ptr_q <= ptr_q + 1'b1;
					if (op == OP_GET && !hit_q && tval_q[pi] && tvol_q[pi] == r_q.volume
						&& tblk_q[pi] == r_q.block) begin
						hit_q <= 1'b1;
						hidx_q <= pi;
					end
					if (op == OP_DRANGE && inr) begin
						if (refc_q[pi] != 0) begin
							stop_q <= 1'b1;
							stat_q <= ST_BUSY;
						end else begin
							tval_q[pi] <= 1'b0;
							tblk_q[pi] <= '1;
							dq_q[pi] <= 1'b1;
						end
					end
					if (op == OP_FRANGE && inr && dirty_q[pi]) fl_q[pi] <= 1'b1;
				end
			end
			if (cmd.decide) begin
				unique case (op)
					OP_GET: begin
						if (r_q.block >= bcnt_q || (r_q.want_new && !r_q.want_dirty)) begin
							stat_q <= ST_INVALID; bad_q <= 1'b1;
						end else if (hit_q) begin
							if (r_q.want_new || kind_q[hidx_q] != r_q.kind) stat_q <= ST_CONFLICT;
							else if (refc_q[hidx_q] == 8'hFF) stat_q <= ST_BUSY;
							else begin
								refc_q[hidx_q] <= refc_q[hidx_q] + 1'b1;
								if (refc_q[hidx_q] == 0) used_q <= used_q + 1'b1;
								if (r_q.want_dirty) dirty_q[hidx_q] <= 1'b1;
								mru_q <= 1'b1;
							end
						end else if (used_q >= 4'(NBUF)) stat_q <= ST_BUSY;
						else ptr_q <= (IW+1)'(NBUF-1);
					end
					OP_PUT: begin
						if (!bok || refc_q[bi] == 0) stat_q <= ST_INVALID;
						else begin
							refc_q[bi] <= refc_q[bi] - 1'b1;
							if (refc_q[bi] == 1 && used_q != 0) used_q <= used_q - 1'b1;
						end
					end
					OP_DIRTY: begin
						if (!bok || refc_q[bi] == 0) stat_q <= ST_INVALID;
						else dirty_q[bi] <= 1'b1;
					end
					OP_BRANCH: begin
						if (!bok || r_q.block >= bcnt_q || refc_q[bi] == 0 || dirty_q[bi])
							stat_q <= ST_INVALID;
						else begin
							dirty_q[bi] <= 1'b1;
							tblk_q[bi] <= r_q.block;
						end
					end
					OP_DISCARD: begin
						if (!bok || refc_q[bi] != 1) stat_q <= ST_INVALID;
						else begin
							refc_q[bi] <= '0;
							tval_q[bi] <= 1'b0;
							tblk_q[bi] <= '1;
							if (used_q != 0) used_q <= used_q - 1'b1;
							hidx_q <= bi;
							found_q <= 1'b1;
						end
					end
					default: ;
				endcase
				spos_q <= '1;
			end
			// victim: walk recency from LRU end down to position 0
			if (cmd.vstep && !vic_q) begin
				if (refc_q[ord_q[pi]] == 0 || ptr_q == '0) begin
					vic_q <= 1'b1;
					if (refc_q[ord_q[pi]] != 0) stat_q <= ST_BUSY;
					else begin
						hidx_q <= ord_q[pi];
						if (tval_q[ord_q[pi]] && dirty_q[ord_q[pi]]) begin
							wbv_q <= 1'b1;
							wbb_q <= tblk_q[ord_q[pi]];
							wbvol_q <= tvol_q[ord_q[pi]];
							wbk_q <= kind_q[ord_q[pi]];
						end
						tval_q[ord_q[pi]] <= 1'b1;
						tblk_q[ord_q[pi]] <= r_q.block;
						tvol_q[ord_q[pi]] <= r_q.volume;
						dirty_q[ord_q[pi]] <= r_q.want_dirty;
						kind_q[ord_q[pi]] <= r_q.kind;
						refc_q[ord_q[pi]] <= 8'd1;
						used_q <= used_q + 1'b1;
						fill_q <= !r_q.want_new;
						mru_q <= 1'b1;
					end
				end else ptr_q <= ptr_q - 1'b1;
			end
			// recency move: first locate, then one swap per cycle
			if (cmd.shift) begin
				if (spos_q == '1) begin
					spos_q <= tpos;
				end else if (mru_q) begin
					if (spos_q != 0) begin
						ord_q[spos_q[IW-1:0]] <= ord_q[spos_q[IW-1:0] - 1'b1];
						ord_q[spos_q[IW-1:0] - 1'b1] <= tgt;
						spos_q <= spos_q - 1'b1;
					end
				end else if (spos_q != (IW+1)'(NBUF-1)) begin
					ord_q[spos_q[IW-1:0]] <= ord_q[spos_q[IW-1:0] + 1'b1];
					ord_q[spos_q[IW-1:0] + 1'b1] <= tgt;
					spos_q <= spos_q + 1'b1;
				end else if (op == OP_DRANGE) begin
					// this one is at the LRU end; go on with the next
					dq_q[tgt] <= 1'b0;
					spos_q <= '1;
				end
			end
			if (cmd.emit && op == OP_FRANGE && fany) begin
				fl_q[fidx] <= 1'b0;
				dirty_q[fidx] <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/bbc_checker.sv =====
// Port-level checker for the cache tag manager, bound to the top level.
// Depends on bbc_pkg and the assertion macro header.
`include "block_buffer_lru_cache_tags_assert.svh"
module bbc_checker import bbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic rsp_valid,
	input rsp_t rsp
);
	`BBC_ASSERT_IMP(a_rsp_busy, clk, arst_n, rsp_valid, busy)
	`BBC_ASSERT_NXT(a_take, clk, arst_n, start && !busy, busy)
	`BBC_ASSERT_NXT(a_last_idle, clk, arst_n, rsp_valid && rsp.last, !busy)
	`BBC_ASSERT_IMP(a_hit_nofill, clk, arst_n, rsp_valid && rsp.was_hit, !rsp.fill_needed)
endmodule

bind block_buffer_lru_cache_tags bbc_checker u_chk (.clk, .arst_n, .start, .busy,
	.rsp_valid, .rsp);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for block_buffer_lru_cache_tags: random and directed cache operations,
// predicted by an in-bench tag/recency model. Depends on bbc_pkg and the block's RTL.
module testbench;
	import bbc_pkg::*;

	localparam int NB = 8;
	localparam int WATCH_LIMIT = 5000;
	localparam int QUIET_CYCLES = 40;

	typedef struct {
		bit          is_cfg;
		logic [31:0] cfg_value;
		req_t        r;
	} pending_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        cfg_we;
	logic [31:0] cfg_data;
	logic        rsp_valid;
	rsp_t        rsp;

	block_buffer_lru_cache_tags dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	pending_t pend_q[$];
	rsp_t     owed_q[$];
	int       errors;
	int       ops_taken;
	int       rsp_seen;
	int       writebacks_seen;
	int       quiet;
	int       idle_run;
	int       gap;
	bit       took;
	bit       stim_done;

	// predicted cache state
	logic [31:0] bc;
	logic [31:0] t_blk[NB];
	bit          t_val[NB];
	logic [7:0]  t_vol[NB];
	int          t_ref[NB];
	bit          t_dirty[NB];
	logic [2:0]  t_kind[NB];
	int          order[NB];   // most recent first
	int          held;        // buffers with nonzero count

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t mk_rsp(stat_t s, int idx, bit hit, bit fill, bit wbv,
			logic [31:0] wbb, logic [7:0] wbvol, logic [2:0] wbk, bit fin);
		rsp_t x;
		x.status = s;
		x.result_index = idx[2:0];
		x.was_hit = hit;
		x.fill_needed = fill;
		x.writeback_valid = wbv;
		x.writeback_block = wbb;
		x.writeback_volume = wbvol;
		x.writeback_kind = wbk;
		x.last = fin;
		return x;
	endfunction

	function automatic rsp_t status_rsp(stat_t s);
		return mk_rsp(s, 0, 0, 0, 0, 0, 0, 0, 1);
	endfunction

	function automatic int pos_of(int b);
		for (int p = 0; p < NB; p++)
			if (order[p] == b) return p;
		return 0;
	endfunction

	function automatic void to_front(int b);
		int p;
		p = pos_of(b);
		for (; p > 0; p--) order[p] = order[p-1];
		order[0] = b;
	endfunction

	function automatic void to_back(int b);
		int p;
		p = pos_of(b);
		for (; p + 1 < NB; p++) order[p] = order[p+1];
		order[NB-1] = b;
	endfunction

	function automatic bit usable(int b, logic [7:0] vol);
		return t_val[b] && t_vol[b] == vol;
	endfunction

	function automatic bit range_good(logic [31:0] s, logic [31:0] c);
		return s < bc && c != 0 && (bc - s) >= c;
	endfunction

	function automatic bit covers(int b, logic [7:0] vol, logic [31:0] s, logic [31:0] c);
		return t_val[b] && t_vol[b] == vol && t_blk[b] >= s &&
			{32'd0, t_blk[b]} < {32'd0, s} + {32'd0, c};
	endfunction

	function automatic void grab(int b, bit dirty);
		t_ref[b]++;
		if (t_ref[b] == 1) held++;
		if (dirty) t_dirty[b] = 1;
		to_front(b);
	endfunction

	function automatic void reset_cache();
		bc = 32'hFFFF_FFFF;
		for (int i = 0; i < NB; i++) begin
			t_blk[i] = 32'hFFFF_FFFF;
			t_val[i] = 0;
			t_vol[i] = 0;
			t_ref[i] = 0;
			t_dirty[i] = 0;
			t_kind[i] = 0;
			order[i] = NB - 1 - i;
		end
		held = 0;
	endfunction

	// get: hit lookup or LRU victim among unreferenced buffers
	function automatic void cache_get(req_t r);
		int p;
		int b;
		rsp_t x;
		if (r.block >= bc || (r.want_new && !r.want_dirty)) begin
			owed_q.push_back(status_rsp(ST_INVALID));
			return;
		end
		for (b = 0; b < NB; b++) begin
			if (usable(b, r.volume) && t_blk[b] == r.block) begin
				if (r.want_new || t_kind[b] != r.kind)
					owed_q.push_back(status_rsp(ST_CONFLICT));
				else if (t_ref[b] == 255)
					owed_q.push_back(status_rsp(ST_BUSY));
				else begin
					grab(b, r.want_dirty);
					owed_q.push_back(mk_rsp(ST_OK, b, 1, 0, 0, 0, 0, 0, 1));
				end
				return;
			end
		end
		if (held >= NB) begin
			owed_q.push_back(status_rsp(ST_BUSY));
			return;
		end
		for (p = NB - 1; p > 0; p--)
			if (t_ref[order[p]] == 0) break;
		b = order[p];
		if (t_ref[b] != 0) begin
			owed_q.push_back(status_rsp(ST_BUSY));
			return;
		end
		x = mk_rsp(ST_OK, b, 0, !r.want_new, 0, 0, 0, 0, 1);
		if (t_val[b] && t_dirty[b]) begin
			x.writeback_valid = 1;
			x.writeback_block = t_blk[b];
			x.writeback_volume = t_vol[b];
			x.writeback_kind = t_kind[b];
		end
		t_val[b] = 1;
		t_blk[b] = r.block;
		t_vol[b] = r.volume;
		t_dirty[b] = 0;
		t_kind[b] = r.kind;
		grab(b, r.want_dirty);
		owed_q.push_back(x);
	endfunction

	// expected transactions for one accepted operation
	function automatic void cache_step(req_t r);
		int b;
		int n;
		int bi;
		bi = r.buffer_index;
		case (op_t'(r.operation))
			OP_GET: cache_get(r);
			OP_PUT: begin
				if (!usable(bi, r.volume) || t_ref[bi] == 0)
					owed_q.push_back(status_rsp(ST_INVALID));
				else begin
					t_ref[bi]--;
					if (t_ref[bi] == 0 && held > 0) held--;
					owed_q.push_back(status_rsp(ST_OK));
				end
			end
			OP_DIRTY: begin
				if (!usable(bi, r.volume) || t_ref[bi] == 0)
					owed_q.push_back(status_rsp(ST_INVALID));
				else begin
					t_dirty[bi] = 1;
					owed_q.push_back(status_rsp(ST_OK));
				end
			end
			OP_BRANCH: begin
				if (!usable(bi, r.volume) || r.block >= bc || t_ref[bi] == 0 || t_dirty[bi])
					owed_q.push_back(status_rsp(ST_INVALID));
				else begin
					t_dirty[bi] = 1;
					t_blk[bi] = r.block;
					owed_q.push_back(status_rsp(ST_OK));
				end
			end
			OP_DISCARD: begin
				if (!usable(bi, r.volume) || t_ref[bi] != 1)
					owed_q.push_back(status_rsp(ST_INVALID));
				else begin
					t_ref[bi] = 0;
					t_val[bi] = 0;
					t_blk[bi] = 32'hFFFF_FFFF;
					if (held > 0) held--;
					to_back(bi);
					owed_q.push_back(status_rsp(ST_OK));
				end
			end
			OP_DRANGE: begin
				if (!range_good(r.block, r.range_count)) begin
					owed_q.push_back(status_rsp(ST_INVALID));
					return;
				end
				for (b = 0; b < NB; b++) begin
					if (covers(b, r.volume, r.block, r.range_count)) begin
						// a referenced buffer stops the scan; earlier ones stay dropped
						if (t_ref[b] != 0) begin
							owed_q.push_back(status_rsp(ST_BUSY));
							return;
						end
						t_val[b] = 0;
						t_blk[b] = 32'hFFFF_FFFF;
						to_back(b);
					end
				end
				owed_q.push_back(status_rsp(ST_OK));
			end
			OP_FRANGE: begin
				if (!range_good(r.block, r.range_count)) begin
					owed_q.push_back(status_rsp(ST_INVALID));
					return;
				end
				n = 0;
				for (b = 0; b < NB && n < NB; b++) begin
					if (covers(b, r.volume, r.block, r.range_count) && t_dirty[b]) begin
						owed_q.push_back(mk_rsp(ST_OK, b, 0, 0, 1, t_blk[b], t_vol[b],
							t_kind[b], 0));
						t_dirty[b] = 0;
						n++;
					end
				end
				if (n == 0) owed_q.push_back(status_rsp(ST_OK));
				else owed_q[$].last = 1;
			end
			default: owed_q.push_back(status_rsp(ST_INVALID));
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_rsp(rsp_t got);
		rsp_t w;
		if (owed_q.size() == 0) begin
			report("unexpected transaction, status", got.status, 0);
			return;
		end
		w = owed_q.pop_front();
		if (got.status !== w.status) report("status", got.status, w.status);
		if (got.result_index !== w.result_index)
			report("result_index", got.result_index, w.result_index);
		if (got.was_hit !== w.was_hit) report("was_hit", got.was_hit, w.was_hit);
		if (got.fill_needed !== w.fill_needed)
			report("fill_needed", got.fill_needed, w.fill_needed);
		if (got.writeback_valid !== w.writeback_valid)
			report("writeback_valid", got.writeback_valid, w.writeback_valid);
		if (got.writeback_block !== w.writeback_block)
			report("writeback_block", got.writeback_block, w.writeback_block);
		if (got.writeback_volume !== w.writeback_volume)
			report("writeback_volume", got.writeback_volume, w.writeback_volume);
		if (got.writeback_kind !== w.writeback_kind)
			report("writeback_kind", got.writeback_kind, w.writeback_kind);
		if (got.last !== w.last) report("last", got.last, w.last);
	endtask

	// monitor: sample at the rising edge, compare before predicting the new transaction
	always @(posedge clk) begin
		took = 0;
		if (arst_n) begin
			if (rsp_valid) begin
				rsp_seen++;
				if (rsp.writeback_valid) writebacks_seen++;
				check_rsp(rsp);
			end
			if (cfg_we) bc = cfg_data;
			if (start && !busy) begin
				took = 1;
				ops_taken++;
				cache_step(req);
			end
			quiet = (owed_q.size() == 0 && !busy && !start) ? quiet + 1 : 0;
			idle_run = (took || rsp_valid || cfg_we) ? 0 : idle_run + 1;
			if (idle_run >= WATCH_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
				$display("block_buffer_lru_cache_tags: mismatch");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// driver: inputs change on the falling edge, one assignment per signal per step
	always @(negedge clk) begin
		bit          n_start;
		bit          n_we;
		pending_t    p;
		if (arst_n) begin
			n_start = start && !took;
			n_we = 0;
			if (!n_start) begin
				if (gap > 0)
					gap--;
				else if (pend_q.size() > 0) begin
					if (pend_q[0].is_cfg) begin
						// register writes only once the block has gone quiet
						if (quiet >= QUIET_CYCLES) begin
							p = pend_q.pop_front();
							cfg_data <= p.cfg_value;
							n_we = 1;
						end
					end else begin
						p = pend_q.pop_front();
						req <= p.r;
						n_start = 1;
						gap = draw_gap();
					end
				end
			end
			start <= n_start;
			cfg_we <= n_we;
		end
	end

	function automatic req_t mk_req(op_t op, logic [31:0] blk, logic [31:0] cnt,
			logic [7:0] vol, logic [2:0] bi, bit wn, bit wd, logic [2:0] kd);
		req_t r;
		r.operation = op;
		r.block = blk;
		r.range_count = cnt;
		r.volume = vol;
		r.buffer_index = bi;
		r.want_new = wn;
		r.want_dirty = wd;
		r.kind = kd;
		return r;
	endfunction

	function automatic void add_op(req_t r);
		pending_t p;
		p.is_cfg = 0;
		p.cfg_value = 0;
		p.r = r;
		pend_q.push_back(p);
	endfunction

	function automatic void add_cfg(logic [31:0] v);
		pending_t p;
		p.is_cfg = 1;
		p.cfg_value = v;
		p.r = '0;
		pend_q.push_back(p);
	endfunction

	function automatic logic [31:0] pick_block(logic [31:0] lim);
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return lim - 1;
			2: return lim;
			3: return 32'hFFFF_FFFE;
			default: return (lim > 12) ? $urandom_range(0, 11) : $urandom_range(0, lim);
		endcase
	endfunction

	function automatic logic [7:0] pick_vol();
		case ($urandom_range(0, 9))
			0: return 8'hFF;
			1: return 8'($urandom_range(0, 255));
			2, 3: return 8'd1;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [31:0] pick_count(logic [31:0] s, logic [31:0] lim);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return lim - s;
			4: return 1;
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	// random mix weighted toward gets and puts so buffers cycle through reuse
	function automatic void add_random(int count, logic [31:0] lim);
		op_t op;
		int k;
		logic [31:0] s;
		bit wn;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 36) op = OP_GET;
			else if (k < 58) op = OP_PUT;
			else if (k < 67) op = OP_DIRTY;
			else if (k < 74) op = OP_BRANCH;
			else if (k < 81) op = OP_DISCARD;
			else if (k < 87) op = OP_DRANGE;
			else if (k < 97) op = OP_FRANGE;
			else op = OP_BAD;
			s = pick_block(lim);
			wn = ($urandom_range(0, 6) == 0);
			add_op(mk_req(op, s, pick_count(s, lim), pick_vol(), 3'($urandom_range(0, 7)),
				wn, wn ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd0));
		end
	endfunction

	initial begin
		errors = 0;
		ops_taken = 0;
		rsp_seen = 0;
		writebacks_seen = 0;
		quiet = 0;
		idle_run = 0;
		gap = 0;
		took = 0;
		stim_done = 0;
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_data = '0;
		reset_cache();
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: extremes, every operation, error cases
		add_cfg(32'd16);
		add_op(mk_req(OP_GET, 16, 0, 0, 0, 0, 0, 0));            // block past limit
		add_op(mk_req(OP_GET, 3, 0, 0, 0, 1, 0, 0));             // new without dirty
		add_op(mk_req(OP_GET, 15, 0, 8'hFF, 0, 1, 1, 3'd7));     // new, dirty metadata
		add_op(mk_req(OP_GET, 15, 0, 8'hFF, 0, 0, 0, 3'd0));     // hit, kind conflict
		add_op(mk_req(OP_GET, 15, 0, 8'hFF, 0, 1, 1, 3'd7));     // hit with want_new
		for (int i = 0; i < 8; i++)                              // fill every buffer
			add_op(mk_req(OP_GET, i, 0, 1, 0, 0, i[0], 0));
		add_op(mk_req(OP_GET, 9, 0, 1, 0, 0, 0, 0));             // all referenced
		add_op(mk_req(OP_DIRTY, 0, 0, 1, 3'd7, 0, 0, 0));
		add_op(mk_req(OP_BRANCH, 12, 0, 1, 3'd7, 0, 0, 0));      // already dirty
		add_op(mk_req(OP_BRANCH, 12, 0, 1, 3'd6, 0, 0, 0));
		add_op(mk_req(OP_DISCARD, 0, 0, 1, 3'd5, 0, 0, 0));
		add_op(mk_req(OP_PUT, 0, 0, 2, 3'd4, 0, 0, 0));          // wrong volume
		add_op(mk_req(OP_DRANGE, 0, 16, 1, 0, 0, 0, 0));         // hits referenced
		add_op(mk_req(OP_FRANGE, 0, 16, 1, 0, 0, 0, 0));         // several write-backs
		add_op(mk_req(OP_FRANGE, 0, 0, 1, 0, 0, 0, 0));          // zero count
		add_op(mk_req(OP_FRANGE, 10, 7, 1, 0, 0, 0, 0));         // past the end
		add_op(mk_req(OP_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1, 1, 3'd7));
		for (int i = 0; i < 8; i++) add_op(mk_req(OP_PUT, 0, 0, 1, 3'(i), 0, 0, 0));
		add_op(mk_req(OP_DRANGE, 0, 16, 1, 0, 0, 0, 0));         // drops unreferenced

		// random phases at several limits, including the extremes
		add_random(50, 32'd16);
		add_cfg(32'd1);
		add_random(30, 32'd1);
		add_cfg(32'hFFFF_FFFF);
		add_random(60, 32'hFFFF_FFFF);
		add_cfg(32'd1000);
		add_random(60, 32'd1000);

		wait (pend_q.size() == 0 && !start && owed_q.size() == 0);
		repeat (60) @(posedge clk);
		$display("ran %0d operations, %0d result transactions, %0d write-backs",
			ops_taken, rsp_seen, writebacks_seen);
		$display("covered gets, puts, dirty, branch, discards and flushes at four limits");
		if (errors == 0 && owed_q.size() == 0)
			$display("block_buffer_lru_cache_tags: match");
		else
			$display("block_buffer_lru_cache_tags: mismatch");
		$finish;
	end
endmodule
